[rtl/plid_pkg.sv]
// Shared types and constants for the positional list insert/delete block.
package plid_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int WORD_W        = 32;
    localparam int POS_W         = 7;
    localparam int SLOT_W        = 7;
    localparam int ACT_W         = 3;
    localparam int GROUP_SIZE    = 32;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_INS_AT    = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_BACK  = 3'd4,
        ACT_DEL_AT    = 3'd5,
        ACT_TRAVERSE  = 3'd6
    } act_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [WORD_W-1:0]  data;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE    = 2'd0,
        S_EXEC    = 2'd1,
        S_COLLECT = 2'd2,
        S_TRAV    = 2'd3
    } state_t;

endpackage

[rtl/plid_cell.sv]
// One list slot: holds a word and shifts, inserts or rotates with its neighbors.
module plid_cell #(
    parameter int DEPTH = plid_pkg::DEPTH_DEFAULT,
    parameter int INDEX = 0
) (
    input  logic                          aclk,
    input  plid_pkg::cell_ctrl_t          ctrl,
    input  logic [$clog2(DEPTH)-1:0]      k,
    input  logic [plid_pkg::WORD_W-1:0]   left_word,
    input  logic [plid_pkg::WORD_W-1:0]   right_word,
    input  logic [plid_pkg::WORD_W-1:0]   head_word,
    output logic [plid_pkg::WORD_W-1:0]   word,
    output logic [plid_pkg::WORD_W-1:0]   gated_word
);
    import plid_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb begin
        word_next = word_reg;
        case (ctrl.op)
            CELL_INS: begin
                if (MY_IDX == k) begin
                    word_next = ctrl.data;
                end else if (MY_IDX > k) begin
                    word_next = left_word;
                end
            end
            CELL_DEL: begin
                if (MY_IDX >= k) begin
                    word_next = right_word;
                end
            end
            CELL_ROT: begin
                // k is the tail slot; the head word wraps around to it
                if (MY_IDX == k) begin
                    word_next = head_word;
                end else if (MY_IDX < k) begin
                    word_next = right_word;
                end
            end
            default: word_next = word_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word       = word_reg;
    assign gated_word = (MY_IDX == k) ? word_reg : '0;

endmodule

[rtl/plid_or_tree.sv]
// Registered two-level OR reduction that picks the selected cell's word.
module plid_or_tree #(
    parameter int DEPTH = plid_pkg::DEPTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         capture,
    input  logic [plid_pkg::WORD_W-1:0]  gated_words [DEPTH],
    output logic [plid_pkg::WORD_W-1:0]  result
);
    import plid_pkg::*;

    localparam int NGROUP = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    logic [WORD_W-1:0] group_reg  [NGROUP];
    logic [WORD_W-1:0] group_next [NGROUP];

    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            group_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (g * GROUP_SIZE + j < DEPTH) begin
                    group_next[g] = group_next[g] | gated_words[g * GROUP_SIZE + j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            for (int g = 0; g < NGROUP; g++) begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    always_comb begin
        result = '0;
        for (int g = 0; g < NGROUP; g++) begin
            result = result | group_reg[g];
        end
    end

endmodule

[rtl/positional_list_insert_delete_top.sv]
// Top level of the positional list: control sequencer, cell chain and output register.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser carries the action
//   (insert front/back/at, delete front/back/at, traverse). Results leave on
//   m_tvalid/m_tready/m_tdata/m_tuser/m_tlast; m_tuser carries the status code.
//   Every item gives one result, except traverse of a non-empty list (one result per
//   entry, m_tlast on the final one) and the unused action code (no result).
// Timing:
//   An item is taken in S_IDLE and executed in S_EXEC; inserts and failed operations
//   wait there for the result register to be free. A successful delete then passes
//   S_COLLECT, where the registered OR tree picks the removed word. Traverse rotates the
//   cell chain by one slot per result in S_TRAV.
//   All cells of the chain shift in the same cycle.
// Reset: aresetn (synchronous, active low) empties the list and drops m_tvalid.
//   Slot contents are not cleared.
// Stall: the result register holds while m_tready is low; the sequencer waits for it.
module positional_list_insert_delete_top #(
    parameter int DEPTH = plid_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [6:0] position, [38:7] data, [39] zero
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] value, [38:32] slot, [39] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);
    import plid_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    trav_reg, trav_next;
    logic [ACT_W-1:0]    op_action_reg;
    logic [POS_W-1:0]    op_pos_reg;
    logic [WORD_W-1:0]   op_data_reg;
    logic [SLOT_W-1:0]   del_slot_reg, del_slot_next;

    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [WORD_W-1:0]   out_value_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic                out_last_reg;

    logic                out_free;
    logic                load_out;
    status_t             ld_status;
    logic [WORD_W-1:0]   ld_value;
    logic [SLOT_W-1:0]   ld_slot;
    logic                ld_last;

    cell_ctrl_t          ctrl;
    logic [IDX_W-1:0]    k;
    logic [WORD_W-1:0]   words [DEPTH];
    logic [WORD_W-1:0]   gated [DEPTH];
    logic [WORD_W-1:0]   picked;

    logic [CMP_W-1:0]    pos_ext, cnt_ext;
    logic                is_full, is_empty;
    logic [CNT_W-1:0]    trav_inc;

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign pos_ext  = CMP_W'(op_pos_reg);
    assign cnt_ext  = CMP_W'(count_reg);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign trav_inc = trav_reg + CNT_W'(1);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        trav_next     = trav_reg;
        del_slot_next = del_slot_reg;
        ctrl.op       = CELL_HOLD;
        ctrl.data     = op_data_reg;
        k             = '0;
        load_out      = 1'b0;
        ld_status     = ST_OK;
        ld_value      = '0;
        ld_slot       = '0;
        ld_last       = 1'b1;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (op_action_reg)
                    ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
                        if (out_free) begin
                            load_out   = 1'b1;
                            state_next = S_IDLE;
                            if (op_action_reg == ACT_INS_AT &&
                                (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))) begin
                                ld_status = ST_RANGE;
                            end else if (is_full) begin
                                ld_status = ST_FULL;
                            end else begin
                                ctrl.op    = CELL_INS;
                                count_next = count_reg + CNT_W'(1);
                                case (op_action_reg)
                                    ACT_INS_FRONT: k = '0;
                                    ACT_INS_BACK:  k = IDX_W'(count_reg);
                                    default:       k = IDX_W'(op_pos_reg - POS_W'(1));
                                endcase
                            end
                        end
                    end
                    ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT: begin
                        if (is_empty) begin
                            if (out_free) begin
                                load_out   = 1'b1;
                                ld_status  = ST_EMPTY;
                                state_next = S_IDLE;
                            end
                        end else if (op_action_reg == ACT_DEL_AT &&
                                     (pos_ext == '0 || pos_ext > cnt_ext)) begin
                            if (out_free) begin
                                load_out   = 1'b1;
                                ld_status  = ST_RANGE;
                                state_next = S_IDLE;
                            end
                        end else begin
                            ctrl.op    = CELL_DEL;
                            count_next = count_reg - CNT_W'(1);
                            state_next = S_COLLECT;
                            case (op_action_reg)
                                ACT_DEL_FRONT: begin
                                    k             = '0;
                                    del_slot_next = SLOT_W'(1);
                                end
                                ACT_DEL_BACK: begin
                                    k             = IDX_W'(count_reg - CNT_W'(1));
                                    del_slot_next = SLOT_W'(count_reg);
                                end
                                default: begin
                                    k             = IDX_W'(op_pos_reg - POS_W'(1));
                                    del_slot_next = op_pos_reg;
                                end
                            endcase
                        end
                    end
                    ACT_TRAVERSE: begin
                        if (is_empty) begin
                            if (out_free) begin
                                load_out   = 1'b1;
                                ld_status  = ST_EMPTY;
                                state_next = S_IDLE;
                            end
                        end else begin
                            trav_next  = '0;
                            state_next = S_TRAV;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_COLLECT: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    ld_value   = picked;
                    ld_slot    = del_slot_reg;
                    state_next = S_IDLE;
                end
            end
            S_TRAV: begin
                k = IDX_W'(count_reg - CNT_W'(1));
                if (out_free) begin
                    load_out  = 1'b1;
                    ld_value  = words[0];
                    ld_slot   = SLOT_W'(trav_inc);
                    ld_last   = (trav_inc == count_reg);
                    ctrl.op   = CELL_ROT;
                    trav_next = trav_inc;
                    if (trav_inc == count_reg) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            trav_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            trav_reg  <= trav_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_action_reg <= s_tuser;
            op_pos_reg    <= s_tdata[6:0];
            op_data_reg   <= s_tdata[38:7];
        end
        del_slot_reg <= del_slot_next;
        if (load_out) begin
            out_status_reg <= ld_status;
            out_value_reg  <= ld_value;
            out_slot_reg   <= ld_slot;
            out_last_reg   <= ld_last;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        plid_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .k          (k),
            .left_word  ((i == 0) ? '0 : words[(i == 0) ? 0 : i - 1]),
            .right_word (words[(i == DEPTH - 1) ? i : i + 1]),
            .head_word  (words[0]),
            .word       (words[i]),
            .gated_word (gated[i])
        );
    end

    plid_or_tree #(
        .DEPTH (DEPTH)
    ) u_or_tree (
        .aclk        (aclk),
        .capture     (ctrl.op == CELL_DEL),
        .gated_words (gated),
        .result      (picked)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_slot_reg, out_value_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above capacity");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (count_reg == $past(count_reg) ||
             count_reg == $past(count_reg) + CNT_W'(1) ||
             count_reg + CNT_W'(1) == $past(count_reg)))
        else $error("element count moved by more than one");

    a_trav_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TRAV) |-> (count_reg != '0 && trav_reg < count_reg))
        else $error("traverse index outside list");

    a_trav_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TRAV) |=> (count_reg == $past(count_reg)))
        else $error("list size changed during traverse");
`endif

endmodule

[sim/testbench.sv]
// Self-checking testbench for the positional list insert/delete block.
`timescale 1ns / 100ps

module testbench;
    import plid_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED = 20;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] data;
        logic              known;
        status_t           st;
        logic [WORD_W-1:0] val;
        logic [SLOT_W-1:0] slot;
    } stim_t;

    typedef struct {
        status_t           status;
        logic [WORD_W-1:0] value;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    positional_list_insert_delete_top #(.DEPTH(DEPTH)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // list shadow, updated as items are accepted
    logic [WORD_W-1:0] list_words[DEPTH];
    int                list_len = 0;
    int                peak_len = 0;
    outcome_t          pending_results[$];
    stim_t             stim_q[$];

    int  gen_len = 0;
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    int  cycles = 0;
    int  errors = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  status_seen[4] = '{0, 0, 0, 0};

    function automatic void post_result(status_t st, logic [WORD_W-1:0] v,
                                        logic [SLOT_W-1:0] sl, logic lst, bit rec);
        if (rec)
            pending_results.push_back('{st, v, sl, lst});
    endfunction

    function automatic void apply_list_action(stim_t it, bit rec);
        int               idx;
        int               i;
        logic [WORD_W-1:0] w;
        idx = 0;
        case (it.act)
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
                if (it.act == ACT_INS_AT && (it.pos < 1 || it.pos > list_len + 1)) begin
                    post_result(ST_RANGE, '0, '0, 1'b1, rec);
                end else if (list_len >= DEPTH) begin
                    post_result(ST_FULL, '0, '0, 1'b1, rec);
                end else begin
                    if (it.act == ACT_INS_BACK)
                        idx = list_len;
                    else if (it.act == ACT_INS_AT)
                        idx = it.pos - 1;
                    for (i = list_len; i > idx; i--)
                        list_words[i] = list_words[i-1];
                    list_words[idx] = it.data;
                    list_len++;
                    if (list_len > peak_len)
                        peak_len = list_len;
                    post_result(ST_OK, '0, '0, 1'b1, rec);
                end
            end
            ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT: begin
                if (list_len == 0) begin
                    post_result(ST_EMPTY, '0, '0, 1'b1, rec);
                end else if (it.act == ACT_DEL_AT && (it.pos < 1 || it.pos > list_len)) begin
                    post_result(ST_RANGE, '0, '0, 1'b1, rec);
                end else begin
                    if (it.act == ACT_DEL_FRONT)
                        idx = 0;
                    else if (it.act == ACT_DEL_BACK)
                        idx = list_len - 1;
                    else
                        idx = it.pos - 1;
                    w = list_words[idx];
                    for (i = idx; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    post_result(ST_OK, w, SLOT_W'(idx + 1), 1'b1, rec);
                end
            end
            ACT_TRAVERSE: begin
                if (list_len == 0)
                    post_result(ST_EMPTY, '0, '0, 1'b1, rec);
                for (i = 0; i < list_len; i++)
                    post_result(ST_OK, list_words[i], SLOT_W'(i + 1),
                                (i + 1 == list_len), rec);
            end
            default: ;
        endcase
    endfunction

    // directed rows; expected result written out where it is obvious
    function automatic stim_t dir_row(int i);
        stim_t r;
        r = '{ACT_UNUSED, '0, '0, 1'b0, ST_OK, '0, '0};
        case (i)
            0:  r = '{ACT_DEL_FRONT, 7'd0,   32'h0,        1'b1, ST_EMPTY, '0, '0};
            1:  r = '{ACT_DEL_BACK,  7'd0,   32'h0,        1'b1, ST_EMPTY, '0, '0};
            2:  r = '{ACT_DEL_AT,    7'd1,   32'h0,        1'b1, ST_EMPTY, '0, '0};
            3:  r = '{ACT_TRAVERSE,  7'd0,   32'h0,        1'b1, ST_EMPTY, '0, '0};
            4:  r = '{ACT_INS_AT,    7'd0,   32'h5,        1'b1, ST_RANGE, '0, '0};
            5:  r = '{ACT_INS_AT,    7'd2,   32'h5,        1'b1, ST_RANGE, '0, '0};
            6:  r = '{ACT_INS_FRONT, 7'd0,   32'h7FFFFFFF, 1'b1, ST_OK,    '0, '0};
            7:  r = '{ACT_INS_BACK,  7'd0,   32'h80000000, 1'b1, ST_OK,    '0, '0};
            8:  r = '{ACT_INS_AT,    7'd3,   32'hFFFFFFFF, 1'b1, ST_OK,    '0, '0};
            9:  r = '{ACT_INS_AT,    7'd1,   32'h0,        1'b1, ST_OK,    '0, '0};
            10: r = '{ACT_INS_AT,    7'h7F,  32'h1,        1'b1, ST_RANGE, '0, '0};
            11: r = '{ACT_UNUSED,    7'h55,  32'hAAAAAAAA, 1'b0, ST_OK,    '0, '0};
            12: r = '{ACT_TRAVERSE,  7'h2A,  32'h55555555, 1'b0, ST_OK,    '0, '0};
            13: r = '{ACT_DEL_AT,    7'd0,   32'h0,        1'b1, ST_RANGE, '0, '0};
            14: r = '{ACT_DEL_AT,    7'd5,   32'h0,        1'b1, ST_RANGE, '0, '0};
            15: r = '{ACT_DEL_AT,    7'd2,   32'h0,        1'b0, ST_OK,    '0, '0};
            16: r = '{ACT_INS_AT,    7'd2,   32'h55555555, 1'b1, ST_OK,    '0, '0};
            17: r = '{ACT_DEL_FRONT, 7'h7F,  32'hAAAAAAAA, 1'b0, ST_OK,    '0, '0};
            18: r = '{ACT_DEL_BACK,  7'h40,  32'h0,        1'b0, ST_OK,    '0, '0};
            19: r = '{ACT_TRAVERSE,  7'd0,   32'h0,        1'b0, ST_OK,    '0, '0};
            default: ;
        endcase
        return r;
    endfunction

    // queue an item and track the list length it leaves behind
    function automatic void push_item(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                      logic [WORD_W-1:0] data, bit known = 1'b0,
                                      status_t st = ST_OK);
        case (act)
            ACT_INS_FRONT, ACT_INS_BACK:
                if (gen_len < DEPTH) gen_len++;
            ACT_INS_AT:
                if (pos >= 1 && pos <= gen_len + 1 && gen_len < DEPTH) gen_len++;
            ACT_DEL_FRONT, ACT_DEL_BACK:
                if (gen_len > 0) gen_len--;
            ACT_DEL_AT:
                if (pos >= 1 && pos <= gen_len) gen_len--;
            default: ;
        endcase
        stim_q.push_back('{act, pos, data, known, st, '0, '0});
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(int top);
        if ($urandom_range(0, 99) < 15)
            return POS_W'($urandom_range(0, 127));
        return POS_W'($urandom_range(1, top));
    endfunction

    function automatic void push_insert();
        logic [ACT_W-1:0] a;
        a = ACT_W'($urandom_range(0, 2));
        push_item(a, a == ACT_INS_AT ? pick_pos(gen_len + 1) : POS_W'($urandom_range(0, 127)),
                  $urandom);
    endfunction

    function automatic void push_delete();
        logic [ACT_W-1:0] a;
        a = ACT_W'($urandom_range(3, 5));
        push_item(a, a == ACT_DEL_AT ? pick_pos(gen_len > 0 ? gen_len : 1)
                                     : POS_W'($urandom_range(0, 127)),
                  $urandom);
    endfunction

    function automatic void queue_random(int n, int grow_pct);
        int done;
        int r;
        done = 0;
        while (done < n) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                push_item(ACT_UNUSED, POS_W'($urandom_range(0, 127)), $urandom);
            end else begin
                done++;
                if (r < 12)
                    push_item(ACT_TRAVERSE, POS_W'($urandom_range(0, 127)), $urandom);
                else if ($urandom_range(0, 99) < grow_pct)
                    push_insert();
                else
                    push_delete();
            end
        end
    endfunction

    task automatic wait_drained();
        while (stim_q.size() != 0 || pending_results.size() != 0)
            @(negedge aclk);
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (stim_q[0].known)
                    pending_results.push_back('{stim_q[0].st, stim_q[0].val,
                                                stim_q[0].slot, 1'b1});
                apply_list_action(stim_q[0], !stim_q[0].known);
                stim_q.pop_front();
                items_sent++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the presented item
            end else if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, stim_q[0].data, stim_q[0].pos};
                s_tuser  <= stim_q[0].act;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        outcome_t exp;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            status_seen[m_tuser]++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d value %h slot %0d last %0b",
                       m_tuser, m_tdata[31:0], m_tdata[38:32], m_tlast);
                errors++;
            end else begin
                exp = pending_results.pop_front();
                if (m_tuser !== exp.status) begin
                    $error("status: expected %0d, got %0d", exp.status, m_tuser);
                    errors++;
                end
                if (m_tdata[31:0] !== exp.value) begin
                    $error("value: expected %h, got %h", exp.value, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[38:32] !== exp.slot) begin
                    $error("slot: expected %0d, got %0d", exp.slot, m_tdata[38:32]);
                    errors++;
                end
                if (m_tlast !== exp.last) begin
                    $error("last: expected %0b, got %0b", exp.last, m_tlast);
                    errors++;
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("positional_list_insert_delete_top regression: fail");
            $finish;
        end
    end

    initial begin
        int i;
        stim_t row;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // no idling: directed rows, then random mix
        for (i = 0; i < N_DIRECTED; i++) begin
            row = dir_row(i);
            push_item(row.act, row.pos, row.data, row.known, row.st);
        end
        queue_random(20, 60);
        wait_drained();

        // sender idling: grow, fill to capacity, hit the full cases
        send_idle_pct = 46;
        queue_random(20, 75);
        while (gen_len < DEPTH)
            push_insert();
        push_item(ACT_INS_FRONT, 7'd0, $urandom);
        push_item(ACT_INS_BACK, 7'd0, $urandom);
        push_item(ACT_INS_AT, 7'd65, $urandom);
        push_item(ACT_INS_AT, 7'd66, $urandom);
        push_item(ACT_TRAVERSE, 7'd0, $urandom);
        push_item(ACT_DEL_AT, 7'd65, $urandom);
        push_item(ACT_DEL_AT, 7'd64, $urandom);
        push_item(ACT_INS_AT, 7'd64, $urandom);
        wait_drained();

        // receiver stalling: traverse the full list, then drain it
        send_idle_pct = 0;
        stall_pct = 46;
        push_item(ACT_TRAVERSE, 7'd0, $urandom);
        queue_random(20, 40);
        while (gen_len > 0)
            push_delete();
        push_item(ACT_DEL_AT, 7'd1, $urandom);
        push_item(ACT_TRAVERSE, 7'd0, $urandom);
        wait_drained();

        // both sides idling
        send_idle_pct = 36;
        stall_pct = 36;
        queue_random(40, 55);
        wait_drained();

        repeat (16) @(posedge aclk);
        $display("%0d items sent, %0d results checked (ok %0d, full %0d, empty %0d, range %0d)",
                 items_sent, results_seen, status_seen[ST_OK], status_seen[ST_FULL],
                 status_seen[ST_EMPTY], status_seen[ST_RANGE]);
        $display("list reached %0d of %0d slots under four idle/stall mixes",
                 peak_len, DEPTH);
        if (errors == 0 && pending_results.size() == 0)
            $display("positional_list_insert_delete_top regression: pass");
        else
            $display("positional_list_insert_delete_top regression: fail");
        $finish;
    end

endmodule
